### src/ndt_pkg.sv
package ndt_pkg;

  localparam int DIV_W      = 16;
  localparam int DIV_STEP_W = 4;

  typedef struct packed {
    logic [63:0] uuid_high;
    logic [63:0] uuid_low;
    logic [47:0] source_address;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

endpackage

### src/ndt_table_mem.sv
module ndt_table_mem #(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  ndt_pkg::entry_t   wr_data,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output ndt_pkg::entry_t   rd_data
);
  import ndt_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### src/ndt_divider.sv
module ndt_divider (
  input  logic                clk,
  input  logic                rst_n,
  input  ndt_pkg::div_req_t   req,
  output ndt_pkg::div_rsp_t   rsp
);
  import ndt_pkg::*;

  localparam logic [DIV_STEP_W-1:0] LAST_STEP = DIV_STEP_W'(DIV_W - 1);

  logic                  busy_r;
  logic                  done_r;
  logic [DIV_STEP_W-1:0] step_r;
  logic [DIV_W-1:0]      rem_r;
  logic [DIV_W-1:0]      dvd_r;
  logic [DIV_W-1:0]      dvs_r;

  logic [DIV_W:0]        trial;
  logic [DIV_W:0]        diff;
  logic                  ge;

  always_comb begin
    trial = {rem_r, dvd_r[DIV_W-1]};
    diff  = trial - {1'b0, dvs_r};
    ge    = trial >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        rem_r  <= '0;
        dvd_r  <= req.dividend;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r  <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        dvd_r  <= {dvd_r[DIV_W-2:0], 1'b0};
        step_r <= step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

### src/neighbor_discovery_table.sv
// a heard neighbor is looked up by a linear scan of the table memory, one entry
// per cycle; a new neighbor then takes up to two iterative modulo passes
// throughput: one request at a time, the next accepted once the previous result is registered
// reset: synchronous active low; count clears, period and base return to 5,
// table contents stay undefined with no clearing pass
module neighbor_discovery_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [63:0] in_uuid_high,
  input  logic [63:0] in_uuid_low,
  input  logic [47:0] in_source_address,
  input  logic        in_random_coin,
  input  logic [15:0] in_random_slot,
  input  logic [15:0] in_random_delay,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_announce,
  output logic        out_rearm,
  output logic [31:0] out_delay_seconds,
  output logic [1:0]  out_table_action,
  output logic [5:0]  out_slot_index,
  output logic [6:0]  out_neighbor_count,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import ndt_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  localparam logic [15:0] BASE_RESET = 16'd5;
  localparam logic [31:0] DELAY_MIN  = 32'd2;

  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_INSERT  = 2'd1;
  localparam logic [1:0] ACT_REPLACE = 2'd2;
  localparam logic [1:0] ACT_KEPT    = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK,
    ST_SCAN,
    ST_NEW,
    ST_DIV_SLOT,
    ST_WRITE,
    ST_DELAY_START,
    ST_DIV_DELAY,
    ST_FINISH
  } state_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  state_t state_r, state_nxt;

  logic [63:0]      hi_r, hi_nxt;
  logic [63:0]      lo_r, lo_nxt;
  logic [47:0]      addr_r, addr_nxt;
  logic             coin_r, coin_nxt;
  logic [15:0]      rslot_r, rslot_nxt;
  logic [15:0]      rdelay_r, rdelay_nxt;

  logic [CNT_W-1:0] scan_idx_r, scan_idx_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      period_r, period_nxt;
  logic [15:0]      base_r, base_nxt;

  logic             res_announce_r, res_announce_nxt;
  logic             res_rearm_r, res_rearm_nxt;
  logic [31:0]      res_delay_r, res_delay_nxt;
  logic [1:0]       res_action_r, res_action_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_announce_r, out_announce_nxt;
  logic             out_rearm_r, out_rearm_nxt;
  logic [31:0]      out_delay_r, out_delay_nxt;
  logic [1:0]       out_action_r, out_action_nxt;
  logic [5:0]       out_slot_r, out_slot_nxt;
  logic [6:0]       out_count_r, out_count_nxt;

  logic             issue;
  logic             match;
  logic             full;
  logic             load;
  logic [31:0]      dbl;
  logic [15:0]      slot_wide;
  logic [15:0]      cnt_wide;

  entry_t           wr_data;
  entry_t           rd_data;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  ndt_table_mem #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (state_r == ST_WRITE),
    .wr_addr (slot_r),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (scan_idx_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  ndt_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    wr_data.uuid_high      = hi_r;
    wr_data.uuid_low       = lo_r;
    wr_data.source_address = addr_r;

    issue = (state_r == ST_SCAN) && (scan_idx_r < cnt_r);
    match = (rd_data.uuid_high == hi_r) && (rd_data.uuid_low == lo_r);
    full  = (cnt_r == DEPTH_CNT);
    dbl   = sat_add(period_r, period_r);
    load  = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);

    div_req.start    = ((state_r == ST_NEW) && full && coin_r)
                    || ((state_r == ST_DELAY_START) && (base_r != 16'd0));
    div_req.dividend = (state_r == ST_NEW) ? rslot_r : rdelay_r;
    div_req.divisor  = (state_r == ST_NEW) ? 16'(cnt_r) : base_r;

    slot_wide = 16'(slot_r);
    cnt_wide  = 16'(cnt_r);
  end

  always_comb begin
    state_nxt        = state_r;
    hi_nxt           = hi_r;
    lo_nxt           = lo_r;
    addr_nxt         = addr_r;
    coin_nxt         = coin_r;
    rslot_nxt        = rslot_r;
    rdelay_nxt       = rdelay_r;
    scan_idx_nxt     = scan_idx_r;
    cmp_vld_nxt      = cmp_vld_r;
    cmp_idx_nxt      = cmp_idx_r;
    cnt_nxt          = cnt_r;
    period_nxt       = period_r;
    base_nxt         = base_r;
    res_announce_nxt = res_announce_r;
    res_rearm_nxt    = res_rearm_r;
    res_delay_nxt    = res_delay_r;
    res_action_nxt   = res_action_r;
    slot_nxt         = slot_r;

    if (cfg_valid) begin
      base_nxt = cfg_data;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          hi_nxt           = in_uuid_high;
          lo_nxt           = in_uuid_low;
          addr_nxt         = in_source_address;
          coin_nxt         = in_random_coin;
          rslot_nxt        = in_random_slot;
          rdelay_nxt       = in_random_delay;
          res_announce_nxt = !in_mode;
          res_rearm_nxt    = 1'b0;
          res_delay_nxt    = '0;
          res_action_nxt   = ACT_NONE;
          slot_nxt         = '0;
          scan_idx_nxt     = '0;
          cmp_vld_nxt      = 1'b0;
          state_nxt        = in_mode ? ST_SCAN : ST_TICK;
        end
      end
      ST_TICK: begin
        period_nxt    = dbl;
        res_rearm_nxt = 1'b1;
        res_delay_nxt = sat_add(dbl, {31'd0, coin_r});
        state_nxt     = ST_FINISH;
      end
      ST_SCAN: begin
        cmp_vld_nxt = issue;
        cmp_idx_nxt = scan_idx_r[IDX_W-1:0];
        if (cmp_vld_r && match) begin
          slot_nxt  = cmp_idx_r;
          state_nxt = ST_FINISH;
        end else if (!issue) begin
          state_nxt = ST_NEW;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      ST_NEW: begin
        if (!full) begin
          slot_nxt       = cnt_r[IDX_W-1:0];
          res_action_nxt = ACT_INSERT;
          state_nxt      = ST_WRITE;
        end else if (coin_r) begin
          state_nxt = ST_DIV_SLOT;
        end else begin
          res_action_nxt = ACT_KEPT;
          slot_nxt       = '0;
          state_nxt      = ST_DELAY_START;
        end
      end
      ST_DIV_SLOT: begin
        if (div_rsp.done) begin
          slot_nxt       = div_rsp.rem[IDX_W-1:0];
          res_action_nxt = ACT_REPLACE;
          state_nxt      = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (res_action_r == ACT_INSERT) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        state_nxt = ST_DELAY_START;
      end
      ST_DELAY_START: begin
        period_nxt    = {16'd0, base_r};
        res_rearm_nxt = 1'b1;
        if (base_r == 16'd0) begin
          res_delay_nxt = DELAY_MIN;
          state_nxt     = ST_FINISH;
        end else begin
          state_nxt = ST_DIV_DELAY;
        end
      end
      ST_DIV_DELAY: begin
        if (div_rsp.done) begin
          res_delay_nxt = 32'(div_rsp.rem) + DELAY_MIN;
          state_nxt     = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt    = (out_valid_r && out_stall) || load;
    out_announce_nxt = out_announce_r;
    out_rearm_nxt    = out_rearm_r;
    out_delay_nxt    = out_delay_r;
    out_action_nxt   = out_action_r;
    out_slot_nxt     = out_slot_r;
    out_count_nxt    = out_count_r;
    if (load) begin
      out_announce_nxt = res_announce_r;
      out_rearm_nxt    = res_rearm_r;
      out_delay_nxt    = res_delay_r;
      out_action_nxt   = res_action_r;
      out_slot_nxt     = slot_wide[5:0];
      out_count_nxt    = cnt_wide[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      period_r    <= {16'd0, BASE_RESET};
      base_r      <= BASE_RESET;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      period_r    <= period_nxt;
      base_r      <= base_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    hi_r           <= hi_nxt;
    lo_r           <= lo_nxt;
    addr_r         <= addr_nxt;
    coin_r         <= coin_nxt;
    rslot_r        <= rslot_nxt;
    rdelay_r       <= rdelay_nxt;
    scan_idx_r     <= scan_idx_nxt;
    cmp_idx_r      <= cmp_idx_nxt;
    res_announce_r <= res_announce_nxt;
    res_rearm_r    <= res_rearm_nxt;
    res_delay_r    <= res_delay_nxt;
    res_action_r   <= res_action_nxt;
    slot_r         <= slot_nxt;
    out_announce_r <= out_announce_nxt;
    out_rearm_r    <= out_rearm_nxt;
    out_delay_r    <= out_delay_nxt;
    out_action_r   <= out_action_nxt;
    out_slot_r     <= out_slot_nxt;
    out_count_r    <= out_count_nxt;
  end

  assign in_stall           = (state_r != ST_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_announce       = out_announce_r;
  assign out_rearm          = out_rearm_r;
  assign out_delay_seconds  = out_delay_r;
  assign out_table_action   = out_action_r;
  assign out_slot_index     = out_slot_r;
  assign out_neighbor_count = out_count_r;

endmodule

### bench/neighbor_discovery_table_tb.sv
module neighbor_discovery_table_tb;

  localparam int DEPTH      = 64;
  localparam int HOLD_AT    = 150;
  localparam int HOLD_LEN   = 600;
  localparam int PHASE_LEN  = 100;
  localparam int NUM_PHASES = 6;

  typedef enum logic {MODE_TICK, MODE_HEARD} mode_e;
  typedef enum logic [1:0] {ACT_NONE, ACT_INSERTED, ACT_REPLACED, ACT_KEPT} action_e;

  typedef struct {
    mode_e       mode;
    logic [63:0] uuid_high;
    logic [63:0] uuid_low;
    logic [47:0] source_address;
    logic        random_coin;
    logic [15:0] random_slot;
    logic [15:0] random_delay;
  } request_t;

  typedef struct {
    logic        announce;
    logic        rearm;
    logic [31:0] delay;
    action_e     action;
    logic [5:0]  slot;
    logic [6:0]  count;
  } result_t;

  typedef struct {
    request_t q;
    bit       typed;
    result_t  want;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_mode;
  logic [63:0] in_uuid_high;
  logic [63:0] in_uuid_low;
  logic [47:0] in_source_address;
  logic        in_random_coin;
  logic [15:0] in_random_slot;
  logic [15:0] in_random_delay;
  logic        out_valid;
  logic        out_stall;
  logic        out_announce;
  logic        out_rearm;
  logic [31:0] out_delay_seconds;
  logic [1:0]  out_table_action;
  logic [5:0]  out_slot_index;
  logic [6:0]  out_neighbor_count;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  // mirror of the neighbor table and timer state
  logic [63:0] stored_high [DEPTH];
  logic [63:0] stored_low  [DEPTH];
  int          known_count = 0;
  logic [31:0] period      = 32'd5;
  logic [15:0] base_period = 16'd5;

  result_t pending_results[$];
  row_t    directed_rows[$];

  int errors        = 0;
  int results_seen  = 0;
  int requests_sent = 0;
  int tick_total    = 0;
  int action_total [4];
  bit quiet         = 1'b0;

  neighbor_discovery_table #(.TABLE_DEPTH(DEPTH)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_uuid_high      (in_uuid_high),
    .in_uuid_low       (in_uuid_low),
    .in_source_address (in_source_address),
    .in_random_coin    (in_random_coin),
    .in_random_slot    (in_random_slot),
    .in_random_delay   (in_random_delay),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_announce      (out_announce),
    .out_rearm         (out_rearm),
    .out_delay_seconds (out_delay_seconds),
    .out_table_action  (out_table_action),
    .out_slot_index    (out_slot_index),
    .out_neighbor_count(out_neighbor_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("neighbor_discovery_table: mismatch");
    $finish;
  end

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic result_t discover_step(input request_t r);
    result_t res;
    bit      found;
    int      i;
    res = '{announce: 1'b0, rearm: 1'b0, delay: 32'd0, action: ACT_NONE,
            slot: 6'd0, count: 7'd0};
    found = 1'b0;
    if (r.mode == MODE_TICK) begin
      tick_total++;
      res.announce = 1'b1;
      period = sat_add32(period, period);
      res.rearm = 1'b1;
      res.delay = sat_add32(period, {31'd0, r.random_coin});
    end else begin
      for (i = 0; i < known_count; i++) begin
        if (!found && stored_high[i] == r.uuid_high && stored_low[i] == r.uuid_low) begin
          found = 1'b1;
          res.slot = i[5:0];
        end
      end
      if (!found) begin
        if (known_count < DEPTH) begin
          i = known_count;
          known_count++;
          res.action = ACT_INSERTED;
        end else if (r.random_coin) begin
          i = {16'd0, r.random_slot} % known_count;
          res.action = ACT_REPLACED;
        end else begin
          i = -1;
          res.action = ACT_KEPT;
        end
        if (i >= 0) begin
          stored_high[i] = r.uuid_high;
          stored_low[i]  = r.uuid_low;
          res.slot = i[5:0];
        end
        period = {16'd0, base_period};
        res.rearm = 1'b1;
        res.delay = (base_period == 16'd0 ? 32'd0 :
                     {16'd0, r.random_delay} % {16'd0, base_period}) + 32'd2;
      end
      action_total[res.action]++;
    end
    res.count = known_count[6:0];
    return res;
  endfunction

  function automatic request_t mk_request(input mode_e m, input logic [63:0] hi,
                                          input logic [63:0] lo, input logic [47:0] addr,
                                          input logic coin, input logic [15:0] rslot,
                                          input logic [15:0] rdelay);
    request_t r;
    r.mode = m;
    r.uuid_high = hi;
    r.uuid_low = lo;
    r.source_address = addr;
    r.random_coin = coin;
    r.random_slot = rslot;
    r.random_delay = rdelay;
    return r;
  endfunction

  function automatic result_t mk_result(input logic ann, input logic rearm,
                                        input logic [31:0] delay, input action_e act,
                                        input logic [5:0] slot, input logic [6:0] count);
    result_t res;
    res.announce = ann;
    res.rearm = rearm;
    res.delay = delay;
    res.action = act;
    res.slot = slot;
    res.count = count;
    return res;
  endfunction

  task automatic add_row(input request_t q, input bit typed, input result_t want);
    row_t row;
    row.q = q;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  function automatic request_t random_request(input bit tick_only);
    request_t    r;
    logic [63:0] w;
    int          pick;
    int          i;
    r.mode = MODE_HEARD;
    r.uuid_high = {$urandom, $urandom};
    r.uuid_low = {$urandom, $urandom};
    w = {$urandom, $urandom};
    r.source_address = w[47:0];
    w = {$urandom, $urandom};
    r.random_coin = w[40];
    r.random_slot = w[15:0];
    r.random_delay = w[31:16];
    pick = tick_only ? 0 : $urandom_range(99);
    if (pick < 20) begin
      r.mode = MODE_TICK;
    end else if (pick < 55 && known_count > 0) begin
      i = $urandom_range(known_count - 1);
      r.uuid_high = stored_high[i];
      r.uuid_low = stored_low[i];
    end else if (pick < 65 && known_count > 0) begin
      // one half of a known identifier
      i = $urandom_range(known_count - 1);
      if ($urandom_range(1)) r.uuid_high = stored_high[i];
      else r.uuid_low = stored_low[i];
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 10) begin
        $display("result %0d: %s expected %0h got %0h", results_seen, name, want, got);
      end
    end
  endtask

  task automatic offer_request(input request_t r, input bit typed, input result_t want);
    result_t predicted;
    in_valid <= 1'b1;
    in_mode <= r.mode;
    in_uuid_high <= r.uuid_high;
    in_uuid_low <= r.uuid_low;
    in_source_address <= r.source_address;
    in_random_coin <= r.random_coin;
    in_random_slot <= r.random_slot;
    in_random_delay <= r.random_delay;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = discover_step(r);
    pending_results.push_back(typed ? want : predicted);
    requests_sent++;
  endtask

  task automatic release_input(input bit drain);
    if (drain || (!quiet && $urandom_range(99) < 34)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
      if (drain) begin
        while (pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
      end
    end
  endtask

  task automatic write_base(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    base_period = value;
  endtask

  // result side
  initial begin
    int      hold_left;
    bit      hold_done;
    result_t want;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("result %0d arrived with no request pending", results_seen);
        end else begin
          want = pending_results.pop_front();
          check_field("announce", want.announce, out_announce);
          check_field("rearm", want.rearm, out_rearm);
          check_field("delay_seconds", want.delay, out_delay_seconds);
          check_field("table_action", want.action, out_table_action);
          check_field("slot_index", want.slot, out_slot_index);
          check_field("neighbor_count", want.count, out_neighbor_count);
        end
      end
      if (results_seen == HOLD_AT && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 34);
      end
    end
  end

  // request side
  initial begin
    logic [15:0] phase_base [NUM_PHASES];
    result_t     none;
    int          p;
    int          n;
    in_valid <= 1'b0;
    in_mode <= 1'b0;
    in_uuid_high <= '0;
    in_uuid_low <= '0;
    in_source_address <= '0;
    in_random_coin <= 1'b0;
    in_random_slot <= '0;
    in_random_delay <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    none = mk_result(1'b0, 1'b0, 32'd0, ACT_NONE, 6'd0, 7'd0);
    add_row(mk_request(MODE_TICK, '0, '0, '0, 1'b0, '0, '0), 1'b1,
            mk_result(1'b1, 1'b1, 32'd10, ACT_NONE, 6'd0, 7'd0));
    add_row(mk_request(MODE_TICK, '1, '1, '1, 1'b1, '1, '1), 1'b1,
            mk_result(1'b1, 1'b1, 32'd21, ACT_NONE, 6'd0, 7'd0));
    add_row(mk_request(MODE_HEARD, '1, '1, '1, 1'b0, '1, '1), 1'b1,
            mk_result(1'b0, 1'b1, 32'd2, ACT_INSERTED, 6'd0, 7'd1));
    add_row(mk_request(MODE_HEARD, '1, '1, '0, 1'b1, '0, '0), 1'b1,
            mk_result(1'b0, 1'b0, 32'd0, ACT_NONE, 6'd0, 7'd1));
    add_row(mk_request(MODE_HEARD, '0, '0, '0, 1'b1, '0, '0), 1'b1,
            mk_result(1'b0, 1'b1, 32'd2, ACT_INSERTED, 6'd1, 7'd2));
    add_row(mk_request(MODE_HEARD, '1, '0, 48'h0000_0000_0001, 1'b0, 16'd1, 16'd4), 1'b1,
            mk_result(1'b0, 1'b1, 32'd6, ACT_INSERTED, 6'd2, 7'd3));
    add_row(mk_request(MODE_HEARD, '0, '1, 48'h8000_0000_0000, 1'b0, 16'd2, 16'd13), 1'b1,
            mk_result(1'b0, 1'b1, 32'd5, ACT_INSERTED, 6'd3, 7'd4));
    add_row(mk_request(MODE_HEARD, '0, '0, '1, 1'b0, '1, '1), 1'b1,
            mk_result(1'b0, 1'b0, 32'd0, ACT_NONE, 6'd1, 7'd4));
    add_row(mk_request(MODE_TICK, '0, '0, '0, 1'b1, '0, '0), 1'b1,
            mk_result(1'b1, 1'b1, 32'd11, ACT_NONE, 6'd0, 7'd4));
    add_row(mk_request(MODE_HEARD, {4{16'hAAAA}}, {4{16'h5555}}, {3{16'h5555}}, 1'b0,
                       16'hAAAA, 16'h5555), 1'b0, none);
    add_row(mk_request(MODE_HEARD, {4{16'h5555}}, {4{16'hAAAA}}, {3{16'hAAAA}}, 1'b1,
                       16'h5555, 16'hAAAA), 1'b0, none);
    add_row(mk_request(MODE_TICK, '0, '0, '0, 1'b0, '0, '0), 1'b0, none);
    add_row(mk_request(MODE_HEARD, {4{16'hAAAA}}, {4{16'h5555}}, '0, 1'b1, '1, '1),
            1'b0, none);
    add_row(mk_request(MODE_TICK, '0, '0, '0, 1'b1, '0, '0), 1'b0, none);

    foreach (directed_rows[i]) begin
      offer_request(directed_rows[i].q, directed_rows[i].typed, directed_rows[i].want);
      release_input(i == directed_rows.size() - 1);
    end

    phase_base[0] = 16'd1;
    phase_base[1] = 16'hFFFF;
    phase_base[2] = 16'($urandom_range(1000, 3));
    phase_base[3] = 16'd0;
    phase_base[4] = 16'd2;
    phase_base[5] = 16'd5;
    for (p = 0; p < NUM_PHASES; p++) begin
      write_base(phase_base[p]);
      quiet = (p == 4);
      for (n = 0; n < PHASE_LEN; n++) begin
        // a run of ticks drives the period into saturation unless the base period is zero
        offer_request(random_request(n >= 40 && n < 75), 1'b0, none);
        release_input(n == PHASE_LEN - 1);
      end
    end
    quiet = 1'b0;
    repeat (120) @(posedge clk);

    $display("%0d requests: %0d ticks, %0d known, %0d inserted, %0d replaced, %0d kept",
             requests_sent, tick_total, action_total[ACT_NONE], action_total[ACT_INSERTED],
             action_total[ACT_REPLACED], action_total[ACT_KEPT]);
    $display("base periods 5, 1, 65535, %0d, 0, 2 and 5 with a full table and a long output hold",
             phase_base[2]);
    if (errors == 0) begin
      $display("neighbor_discovery_table: match");
    end else begin
      $display("neighbor_discovery_table: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
src/ndt_pkg.sv
src/ndt_table_mem.sv
src/ndt_divider.sv
src/neighbor_discovery_table.sv
bench/neighbor_discovery_table_tb.sv
